### design/sre_pkg.sv
// ----------------------------------------------------------------------------
// sre_pkg: shared codes for the stack relocation evaluator
// Relocation kind codes, status codes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sre_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned INSN_W  = 32;
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SHAMT_W = 6;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] status_t;

  // relocation kinds
  localparam mode_t MODE_ABS32          = 4'd0;
  localparam mode_t MODE_ABS64          = 4'd1;
  localparam mode_t MODE_PUSH_PCREL     = 4'd2;
  localparam mode_t MODE_PUSH_ABS       = 4'd3;
  localparam mode_t MODE_PUSH_GPREL     = 4'd4;
  localparam mode_t MODE_PUSH_PLT_PCREL = 4'd5;
  localparam mode_t MODE_SUB            = 4'd6;
  localparam mode_t MODE_SHL            = 4'd7;
  localparam mode_t MODE_SAR            = 4'd8;
  localparam mode_t MODE_ADD            = 4'd9;
  localparam mode_t MODE_POP_10_12      = 4'd10;
  localparam mode_t MODE_POP_10_16_S2   = 4'd11;
  localparam mode_t MODE_POP_5_20       = 4'd12;
  localparam mode_t MODE_POP_0_5_10_16  = 4'd13;
  localparam mode_t MODE_POP_0_10_10_16 = 4'd14;

  // result status
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_UNDERFLOW = 3'd1;
  localparam status_t ST_OVERFLOW  = 3'd2;
  localparam status_t ST_RANGE     = 3'd3;
  localparam status_t ST_UNALIGNED = 3'd4;
  localparam status_t ST_UNSUPP    = 3'd5;

endpackage

`default_nettype wire

### design/stack_relocation_evaluator.sv
// ----------------------------------------------------------------------------
// stack_relocation_evaluator: relocation records against a value stack
// Absolute stores, stack pushes, binary stack ops and pop-and-patch kinds.
// ----------------------------------------------------------------------------
// The block accepts one relocation record per cycle and returns one result
// word per record. A record is held in the input register, then its word in
// the result register, which drives the outputs. While out_ready stays high
// the sustained rate is one record per clock:
// the value stack is a row of shifting registers whose top two entries feed
// the arithmetic, and the stack and its count update in the same cycle the
// record is evaluated, so the next record sees them at once. While a result
// waits for out_ready, the input register takes at most one more record and
// then holds in_ready low until the result word is taken. Stack entries are
// not cleared by reset; the count is, so no entry is read before it has been
// written.
`timescale 1ns / 1ps
`default_nettype none

module stack_relocation_evaluator
  import sre_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [WORD_W-1:0]   sym_value,
  input  wire logic                sym_present,
  input  wire logic signed [WORD_W-1:0] addend,
  input  wire logic [WORD_W-1:0]   place_address,
  input  wire logic [INSN_W-1:0]   current_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STAT_W-1:0]        status,
  output logic                     write_valid,
  output logic                     write_is_64,
  output logic [WORD_W-1:0]        write_data
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_POP_REPLACE
  } stk_op_t;

  // input register
  logic              in_q_valid;
  mode_t             in_mode;
  logic [WORD_W-1:0] in_sym;
  logic [WORD_W-1:0] in_addend;
  logic [WORD_W-1:0] in_place;
  logic [INSN_W-1:0] in_word;

  // stack
  logic [WORD_W-1:0] stack_entries [STACK_DEPTH];
  logic [CNT_W-1:0]  stack_top;

  // evaluation
  logic              advance;
  logic              fire;
  stk_op_t           stk_op;
  logic [WORD_W-1:0] stk_val;
  logic [WORD_W-1:0] sum_abs;
  logic [WORD_W-1:0] sum_pcrel;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] bin_res;
  logic [WORD_W-1:0] pop_sh;
  logic [INSN_W-1:0] patched;
  logic              fits_ok;
  logic              stk_full;
  logic              stk_empty;
  status_t           status_next;
  logic              wv_next;
  logic              w64_next;
  logic [WORD_W-1:0] data_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;
  assign fire     = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_mode   <= mode;
      in_sym    <= sym_present ? sym_value : '0;
      in_addend <= addend;
      in_place  <= place_address;
      in_word   <= current_word;
    end
  end

  assign stk_full  = (stack_top == CNT_FULL);
  assign stk_empty = (stack_top == '0);
  assign opb       = stack_entries[0];
  assign opa       = stack_entries[1];
  assign sum_abs   = in_sym + in_addend;
  assign sum_pcrel = sum_abs - in_place;

  always_comb begin
    case (in_mode)
      MODE_SUB: bin_res = opa - opb;
      MODE_SHL: bin_res = opa << opb[SHAMT_W-1:0];
      MODE_SAR: bin_res = WORD_W'($signed(opa) >>> opb[SHAMT_W-1:0]);
      default:  bin_res = opa + opb;
    endcase
  end

  // scaled kinds drop the two alignment bits, keeping the sign
  always_comb begin
    if (in_mode == MODE_POP_10_12 || in_mode == MODE_POP_5_20) begin
      pop_sh = opb;
    end else begin
      pop_sh = {{2{opb[WORD_W-1]}}, opb[WORD_W-1:2]};
    end
  end

  always_comb begin
    case (in_mode)
      MODE_POP_10_12: begin
        fits_ok = (&pop_sh[WORD_W-1:11]) || !(|pop_sh[WORD_W-1:11]);
        patched = {in_word[31:22], pop_sh[11:0], in_word[9:0]};
      end
      MODE_POP_10_16_S2: begin
        fits_ok = (&pop_sh[WORD_W-1:15]) || !(|pop_sh[WORD_W-1:15]);
        patched = {in_word[31:26], pop_sh[15:0], in_word[9:0]};
      end
      MODE_POP_5_20: begin
        fits_ok = (&pop_sh[WORD_W-1:19]) || !(|pop_sh[WORD_W-1:19]);
        patched = {in_word[31:25], pop_sh[19:0], in_word[4:0]};
      end
      MODE_POP_0_5_10_16: begin
        fits_ok = (&pop_sh[WORD_W-1:20]) || !(|pop_sh[WORD_W-1:20]);
        patched = {in_word[31:26], pop_sh[15:0], in_word[9:5], pop_sh[20:16]};
      end
      default: begin
        fits_ok = (&pop_sh[WORD_W-1:25]) || !(|pop_sh[WORD_W-1:25]);
        patched = {in_word[31:26], pop_sh[15:0], pop_sh[25:16]};
      end
    endcase
  end

  always_comb begin
    stk_op      = STK_HOLD;
    stk_val     = bin_res;
    status_next = ST_OK;
    wv_next     = 1'b0;
    w64_next    = 1'b0;
    data_next   = '0;
    case (in_mode)
      MODE_ABS32: begin
        wv_next   = 1'b1;
        data_next = {32'd0, sum_abs[31:0]};
      end
      MODE_ABS64: begin
        wv_next   = 1'b1;
        w64_next  = 1'b1;
        data_next = sum_abs;
      end
      MODE_PUSH_PCREL, MODE_PUSH_PLT_PCREL, MODE_PUSH_ABS: begin
        stk_val = (in_mode == MODE_PUSH_ABS) ? sum_abs : sum_pcrel;
        if (stk_full) begin
          status_next = ST_OVERFLOW;
        end else begin
          stk_op = STK_PUSH;
        end
      end
      MODE_PUSH_GPREL: begin
        stk_op = STK_HOLD;
      end
      MODE_SUB, MODE_SHL, MODE_SAR, MODE_ADD: begin
        if (stk_empty) begin
          status_next = ST_UNDERFLOW;
        end else if (stack_top == CNT_ONE) begin
          // lone operand is consumed anyway
          status_next = ST_UNDERFLOW;
          stk_op      = STK_POP;
        end else begin
          stk_op = STK_POP_REPLACE;
        end
      end
      MODE_POP_10_12, MODE_POP_10_16_S2, MODE_POP_5_20,
      MODE_POP_0_5_10_16, MODE_POP_0_10_10_16: begin
        if (stk_empty) begin
          status_next = ST_UNDERFLOW;
        end else begin
          stk_op = STK_POP;
          if (in_mode != MODE_POP_10_12 && in_mode != MODE_POP_5_20 &&
              opb[1:0] != 2'b00) begin
            status_next = ST_UNALIGNED;
          end else if (!fits_ok) begin
            status_next = ST_RANGE;
          end else begin
            wv_next   = 1'b1;
            data_next = {32'd0, patched};
          end
        end
      end
      default: begin
        status_next = ST_UNSUPP;
      end
    endcase
  end

  // stack entries carry no reset; the count guards every read
  always_ff @(posedge clk) begin
    if (fire) begin
      case (stk_op)
        STK_PUSH: begin
          stack_entries[0] <= stk_val;
          for (int i = 1; i < STACK_DEPTH; i++) begin
            stack_entries[i] <= stack_entries[i-1];
          end
        end
        STK_POP: begin
          for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            stack_entries[i] <= stack_entries[i+1];
          end
        end
        STK_POP_REPLACE: begin
          stack_entries[0] <= stk_val;
          for (int i = 1; i < STACK_DEPTH - 1; i++) begin
            stack_entries[i] <= stack_entries[i+1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_top <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        case (stk_op)
          STK_PUSH:                 stack_top <= stack_top + CNT_ONE;
          STK_POP, STK_POP_REPLACE: stack_top <= stack_top - CNT_ONE;
          default:                  stack_top <= stack_top;
        endcase
      end
      if (advance) begin
        out_valid <= in_q_valid;
      end
    end
    if (fire) begin
      status      <= status_next;
      write_valid <= wv_next;
      write_is_64 <= w64_next;
      write_data  <= data_next;
    end
  end

endmodule

`default_nettype wire
